// File: rtl/keyed_table_with_age_eviction_assert.svh
// Assertion macros shared by the keyed table checker.
// Depends on nothing; the including module supplies clock and reset.
`ifndef KEYED_TABLE_WITH_AGE_EVICTION_ASSERT_SVH
`define KEYED_TABLE_WITH_AGE_EVICTION_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, muted in reset
`define KTA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keyed table check failed");

// Next-cycle implication, sampled on the rising clock edge, muted in reset
`define KTA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keyed table check failed");

`endif

// File: rtl/kta_pkg.sv
// Shared types and constants of the keyed table with age eviction.
// Used by kta_cell, the top level and the checker; depends on nothing.
package kta_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int KEY_W         = 32;
   localparam int HANDLE_W      = 32;
   localparam int AGE_W         = 8;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = AGE_W'(25);

   // register index, taken from the word address
   localparam logic CSR_IDX_AGE_LIMIT = 1'b0;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_DUP      = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_EVICTED  = 3'd4;
   localparam logic [2:0] ST_NONE     = 3'd5;

   // command token that walks the row of cells, one cell per cycle unless the row stalls
   typedef struct packed {
      logic                 active;
      cmd_type              cmd;
      logic [KEY_W-1:0]     key;
      logic [HANDLE_W-1:0]  value;
      logic                 hit;
      logic                 free_found;
      logic [IDX_W-1:0]     free_idx;
      logic                 pend_valid;
      logic [HANDLE_W-1:0]  pend_handle;
   } token_type;

   // eviction handed out of a cell to the result register
   typedef struct packed {
      logic                valid;
      logic [HANDLE_W-1:0] handle;
   } emit_type;

   // entry write for a successful add, decoded by index in each cell
   typedef struct packed {
      logic                en;
      logic [IDX_W-1:0]    idx;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] value;
      logic [AGE_W-1:0]    age;
   } fill_type;

endpackage

// File: rtl/kta_cell.sv
// One table entry of the keyed table: valid, key, handle and age counter.
// Processes the token from its left neighbor and registers it to the right.
// Depends on kta_pkg.
module kta_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [kta_pkg::IDX_W-1:0]     cell_idx,
   input  logic                          advance,
   input  logic [kta_pkg::AGE_W-1:0]     age_limit,
   input  kta_pkg::fill_type             fill,
   input  kta_pkg::token_type            tok_left,
   output kta_pkg::token_type            tok_right,
   output kta_pkg::emit_type             emit
);
   import kta_pkg::*;

   logic                valid_ff, valid_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [HANDLE_W-1:0] value_ff, value_in;
   logic [AGE_W-1:0]    age_ff, age_in;
   token_type           tok_right_ff, tok_right_in;
   logic                match;

   assign match = valid_ff && (key_ff == tok_left.key);

   // act on the token while it sits at this cell
   always_comb begin
      tok_right_in = tok_left;
      valid_in     = valid_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      age_in       = age_ff;
      emit         = '0;
      if (tok_left.active) begin
         unique case (tok_left.cmd)
            CMD_ADD: begin
               if (match) begin
                  tok_right_in.hit = 1'b1;
               end
               if (!valid_ff && !tok_left.free_found) begin
                  tok_right_in.free_found = 1'b1;
                  tok_right_in.free_idx   = cell_idx;
               end
            end
            CMD_REMOVE: begin
               if (match && !tok_left.hit) begin
                  valid_in         = 1'b0;
                  tok_right_in.hit = 1'b1;
               end
            end
            CMD_LOOKUP: begin
               if (match && !tok_left.hit) begin
                  age_in                   = age_limit;
                  tok_right_in.hit         = 1'b1;
                  tok_right_in.pend_handle = value_ff;
               end
            end
            CMD_TICK: begin
               if (valid_ff) begin
                  if (age_ff <= AGE_W'(1)) begin
                     // evict; the previously held eviction now goes out as not last
                     valid_in = 1'b0;
                     age_in   = '0;
                     if (tok_left.pend_valid) begin
                        emit.valid  = 1'b1;
                        emit.handle = tok_left.pend_handle;
                     end
                     tok_right_in.pend_valid  = 1'b1;
                     tok_right_in.pend_handle = value_ff;
                  end else begin
                     age_in = age_ff - AGE_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
      // write a new entry at the end of a successful add
      if (fill.en && (fill.idx == cell_idx)) begin
         valid_in = 1'b1;
         key_in   = fill.key;
         value_in = fill.value;
         age_in   = fill.age;
      end
   end

   // advance entry state and token together
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_right_ff <= '0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         tok_right_ff <= tok_right_in;
      end
   end

   // payload holds, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         key_ff   <= key_in;
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign tok_right = tok_right_ff;

endmodule

// File: rtl/keyed_table_with_age_eviction.sv
// Top level of the keyed table with age eviction: handshakes, age limit
// register, command token issue and result register. Depends on kta_pkg, kta_cell.
//
//   channel  ports                                   direction  transfer when
//   req      req_cmd, req_key_tag, req_value_handle  in         req_valid & req_ready
//   rsp      rsp_status, rsp_result_handle, rsp_last out        rsp_valid & rsp_ready
//   csr      csr_p* (APB-style, one register)        in/out     psel & penable
//
// An accepted command becomes a token that walks the row of TABLE_ENTRIES cells,
// one cell per cycle unless the row stalls. One item is in the row at a time.
// A tick hands out each eviction as the token passes the next evicting cell; a
// full result register stalls the whole row when a cell hands out an eviction or
// the token reaches the end. Reset clears valid bits at once, no clearing pass.
// A new command is taken while the final result still waits.
module keyed_table_with_age_eviction (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_cmd,
   input  logic [kta_pkg::KEY_W-1:0]        req_key_tag,
   input  logic [kta_pkg::HANDLE_W-1:0]     req_value_handle,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_status,
   output logic [kta_pkg::HANDLE_W-1:0]     rsp_result_handle,
   output logic                             rsp_last,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [kta_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [kta_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [kta_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import kta_pkg::*;

   logic [AGE_W-1:0]    age_limit_ff;
   logic                busy_ff;
   token_type           tok0_ff, tok0_in;
   logic                rsp_valid_ff;
   logic [2:0]          rsp_status_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic                rsp_last_ff;

   token_type           tok_link [TABLE_ENTRIES+1];
   emit_type            cell_emit [TABLE_ENTRIES];
   emit_type            emit_any;
   fill_type            fill;
   token_type           tok_end;
   logic                out_can_load;
   logic                advance;
   logic                end_fire;
   logic                req_accept;
   logic                csr_write;
   logic [2:0]          end_status;
   logic [HANDLE_W-1:0] end_handle;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_AGE_LIMIT) ?
                       CSR_DATA_W'(age_limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff <= AGE_LIMIT_RESET;
      end else if (csr_write && (csr_paddr[2] == CSR_IDX_AGE_LIMIT)) begin
         age_limit_ff <= csr_pwdata[AGE_W-1:0];
      end
   end

   // row control
   assign tok_link[0]  = tok0_ff;
   assign tok_end      = tok_link[TABLE_ENTRIES];
   assign out_can_load = !rsp_valid_ff || rsp_ready;
   assign advance      = out_can_load || !(emit_any.valid || tok_end.active);
   assign end_fire     = tok_end.active && out_can_load;
   assign req_ready    = !busy_ff;
   assign req_accept   = req_valid && req_ready;

   // collect the one eviction a cell may hand out
   always_comb begin
      emit_any = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         emit_any.valid  = emit_any.valid | cell_emit[i].valid;
         emit_any.handle = emit_any.handle | cell_emit[i].handle;
      end
   end

   // final result once the token leaves the last cell
   always_comb begin
      end_status  = ST_OK;
      end_handle  = '0;
      fill        = '0;
      fill.idx    = tok_end.free_idx;
      fill.key    = tok_end.key;
      fill.value  = tok_end.value;
      fill.age    = age_limit_ff;
      unique case (tok_end.cmd)
         CMD_ADD: begin
            if (tok_end.hit) begin
               end_status = ST_DUP;
            end else if (!tok_end.free_found) begin
               end_status = ST_FULL;
            end else begin
               end_status = ST_OK;
               fill.en    = end_fire;
            end
         end
         CMD_REMOVE: begin
            end_status = tok_end.hit ? ST_OK : ST_NOTFOUND;
         end
         CMD_LOOKUP: begin
            if (tok_end.hit) begin
               end_status = ST_OK;
               end_handle = tok_end.pend_handle;
            end else begin
               end_status = ST_NOTFOUND;
            end
         end
         CMD_TICK: begin
            if (tok_end.pend_valid) begin
               end_status = ST_EVICTED;
               end_handle = tok_end.pend_handle;
            end else begin
               end_status = ST_NONE;
            end
         end
         default: begin
         end
      endcase
   end

   // issue a token on transfer, drop it once it moves into the row
   always_comb begin
      tok0_in = tok0_ff;
      if (req_accept) begin
         tok0_in        = '0;
         tok0_in.active = 1'b1;
         tok0_in.cmd    = cmd_type'(req_cmd);
         tok0_in.key    = req_key_tag;
         tok0_in.value  = req_value_handle;
      end else if (advance) begin
         tok0_in.active = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok0_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         tok0_ff <= tok0_in;
         if (req_accept) begin
            busy_ff <= 1'b1;
         end else if (end_fire) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit_any.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (end_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit_any.valid) begin
         rsp_status_ff <= ST_EVICTED;
         rsp_handle_ff <= emit_any.handle;
         rsp_last_ff   <= 1'b0;
      end else if (end_fire) begin
         rsp_status_ff <= end_status;
         rsp_handle_ff <= end_handle;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_handle = rsp_handle_ff;
   assign rsp_last          = rsp_last_ff;

   // row of entry cells
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      kta_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(g)),
         .advance   (advance),
         .age_limit (age_limit_ff),
         .fill      (fill),
         .tok_left  (tok_link[g]),
         .tok_right (tok_link[g+1]),
         .emit      (cell_emit[g])
      );
   end

endmodule

// File: rtl/kta_checker.sv
// Port-level checks of the keyed table with age eviction, bound to the top.
// Depends on kta_pkg and keyed_table_with_age_eviction_assert.svh.
`include "keyed_table_with_age_eviction_assert.svh"

module kta_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [2:0]                   rsp_status,
   input logic [kta_pkg::HANDLE_W-1:0] rsp_result_handle,
   input logic                         rsp_last
);
   import kta_pkg::*;

   logic rsp_no_handle;

   // results other than an OK status or an eviction
   assign rsp_no_handle = rsp_valid && (rsp_status != ST_OK) && (rsp_status != ST_EVICTED);

   // hold a result until its transfer
   `KTA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // one command at a time: no new transfer right after one
   `KTA_ASSERT_NEXT(a_req_single, req_valid && req_ready, !req_ready)

   // only lookup hits and evictions carry a handle
   `KTA_ASSERT_NOW(a_handle_zero, rsp_no_handle, rsp_result_handle == '0)

   // every result other than an eviction closes its command
   `KTA_ASSERT_NOW(a_last_single, rsp_valid && rsp_status != ST_EVICTED, rsp_last)

endmodule

bind keyed_table_with_age_eviction kta_checker u_kta_checker (.*);

// File: test/keyed_table_with_age_eviction_tb.sv
// Self-checking testbench for keyed_table_with_age_eviction: directed and random
// commands, age limit register sweeps, random stalls on both channels.
// Depends on kta_pkg and the keyed_table_with_age_eviction RTL.
module keyed_table_with_age_eviction_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kta_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int KEY_POOL_SIZE = 20;
   localparam logic [CSR_ADDR_W-1:0] AGE_LIMIT_ADDR = CSR_ADDR_W'(4 * int'(CSR_IDX_AGE_LIMIT));

   typedef struct packed {
      logic [2:0]          status;
      logic [HANDLE_W-1:0] handle;
      logic                last;
   } table_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_cmd = CMD_TICK;
   logic [KEY_W-1:0]      req_key_tag = '0;
   logic [HANDLE_W-1:0]   req_value_handle = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [2:0]            rsp_status;
   logic [HANDLE_W-1:0]   rsp_result_handle;
   logic                  rsp_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // mirror of the table contents and the age limit register
   logic                  slot_valid [TABLE_ENTRIES];
   logic [KEY_W-1:0]      slot_key   [TABLE_ENTRIES];
   logic [HANDLE_W-1:0]   slot_value [TABLE_ENTRIES];
   logic [AGE_W-1:0]      slot_age   [TABLE_ENTRIES];
   logic [AGE_W-1:0]      age_limit_q;

   table_result_type      pending_results [$];
   logic [KEY_W-1:0]      key_pool [KEY_POOL_SIZE];
   int                    mismatch_count = 0;
   int                    commands_sent = 0;
   int                    results_checked = 0;
   int                    evictions_seen = 0;
   int                    limit_writes = 0;
   int                    quiet_cycles = 0;
   bit                    no_idle = 1'b0;

   keyed_table_with_age_eviction u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_key_tag       (req_key_tag),
      .req_value_handle  (req_value_handle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_result_handle (rsp_result_handle),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // mostly short gaps, a few long ones; none while no_idle is set
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic void push_result(logic [2:0] st, logic [HANDLE_W-1:0] h, logic l);
      table_result_type r;
      r.status = st;
      r.handle = h;
      r.last   = l;
      pending_results.push_back(r);
   endfunction

   // apply one command to the mirror and queue the results it causes
   function automatic void apply_table_command(cmd_type cmd, logic [KEY_W-1:0] key,
                                               logic [HANDLE_W-1:0] val);
      int hit_slot;
      int free_slot;
      int expiring;
      int emitted;
      hit_slot  = -1;
      free_slot = -1;
      expiring  = 0;
      emitted   = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (slot_valid[i] && slot_key[i] == key && hit_slot < 0) hit_slot = i;
         if (!slot_valid[i] && free_slot < 0) free_slot = i;
         if (slot_valid[i] && slot_age[i] <= 1) expiring++;
      end
      case (cmd)
         CMD_ADD: begin
            if (hit_slot >= 0) begin
               push_result(ST_DUP, '0, 1'b1);
            end else if (free_slot < 0) begin
               push_result(ST_FULL, '0, 1'b1);
            end else begin
               slot_valid[free_slot] = 1'b1;
               slot_key[free_slot]   = key;
               slot_value[free_slot] = val;
               slot_age[free_slot]   = age_limit_q;
               push_result(ST_OK, '0, 1'b1);
            end
         end
         CMD_REMOVE: begin
            if (hit_slot < 0) begin
               push_result(ST_NOTFOUND, '0, 1'b1);
            end else begin
               slot_valid[hit_slot] = 1'b0;
               push_result(ST_OK, '0, 1'b1);
            end
         end
         CMD_LOOKUP: begin
            if (hit_slot < 0) begin
               push_result(ST_NOTFOUND, '0, 1'b1);
            end else begin
               slot_age[hit_slot] = age_limit_q;
               push_result(ST_OK, slot_value[hit_slot], 1'b1);
            end
         end
         default: begin
            // age every entry in slot order, evict on a counter of zero or one
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (slot_valid[i]) begin
                  if (slot_age[i] <= 1) begin
                     slot_age[i]   = '0;
                     slot_valid[i] = 1'b0;
                     emitted++;
                     push_result(ST_EVICTED, slot_value[i], emitted == expiring);
                  end else begin
                     slot_age[i] = slot_age[i] - 1'b1;
                  end
               end
            end
            if (expiring == 0) push_result(ST_NONE, '0, 1'b1);
         end
      endcase
   endfunction

   // sample transfers on all ports, update the mirror and check results
   always @(posedge clock) begin : transfer_monitor
      table_result_type want;
      bit moved;
      moved = 1'b0;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
         age_limit_q = AGE_LIMIT_RESET;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            age_limit_q = csr_pwdata[AGE_W-1:0];
            limit_writes++;
            moved = 1'b1;
         end
         if (req_valid && req_ready) begin
            apply_table_command(cmd_type'(req_cmd), req_key_tag, req_value_handle);
            commands_sent++;
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            results_checked++;
            if (rsp_status === ST_EVICTED) evictions_seen++;
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending: status %0d handle %h",
                                         rsp_status, rsp_result_handle));
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, wanted %0d", rsp_status, want.status));
               if (rsp_result_handle !== want.handle)
                  report_mismatch($sformatf("handle %h, wanted %h",
                                            rsp_result_handle, want.handle));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %b, wanted %b", rsp_last, want.last));
            end
         end
         // watchdog on cycles without any transfer
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // random back-pressure on the result channel
   initial begin : rsp_stall
      int n;
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // present one command and hold it until the transfer
   task automatic send_item(cmd_type c, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= c;
      req_key_tag      <= k;
      req_value_handle <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drop valid, let every pending result arrive, then let the row settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TABLE_ENTRIES + 4) @(posedge clock);
   endtask

   task automatic csr_write_age_limit(logic [AGE_W-1:0] limit);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= AGE_LIMIT_ADDR;
      csr_pwdata  <= CSR_DATA_W'(limit);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check_age_limit();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= AGE_LIMIT_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[AGE_W-1:0] !== age_limit_q)
         report_mismatch($sformatf("age limit reads %0d, wanted %0d",
                                   csr_prdata[AGE_W-1:0], age_limit_q));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // empty table: misses on every keyed command, nothing to age out
   task automatic test_empty_table();
      csr_check_age_limit();
      send_item(CMD_LOOKUP, 32'h1234_5678, 32'hFFFF_FFFF);
      send_item(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_item(CMD_TICK, 32'h0, 32'h0);
   endtask

   // add at the key extremes, duplicate, lookup and remove
   task automatic test_basic_commands();
      send_item(CMD_ADD, 32'h0, 32'h0);
      send_item(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_ADD, 32'hFFFF_FFFF, 32'h5555_AAAA);
      send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      send_item(CMD_REMOVE, 32'h0, 32'h0);
      send_item(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
      send_item(CMD_LOOKUP, 32'h0, 32'h0);
   endtask

   // fill every slot at the shortest age, reject one more, evict all at once
   task automatic test_full_table();
      wait_idle();
      csr_write_age_limit(8'd1);
      csr_check_age_limit();
      for (int i = 0; i < TABLE_ENTRIES; i++) send_item(CMD_ADD, 32'h1000_0000 + i, $urandom);
      send_item(CMD_ADD, 32'hDEAD_0000, $urandom);
      send_item(CMD_TICK, 32'h0, 32'h0);
   endtask

   // an age limit of zero stores a dead counter, evicted on the next tick
   task automatic test_zero_age();
      wait_idle();
      csr_write_age_limit(8'd0);
      csr_check_age_limit();
      send_item(CMD_ADD, 32'hA5A5_5A5A, 32'h0F0F_F0F0);
      send_item(CMD_LOOKUP, 32'hA5A5_5A5A, 32'h0);
      send_item(CMD_TICK, 32'h0, 32'h0);
      send_item(CMD_TICK, 32'h0, 32'h0);
   endtask

   // one phase of random traffic on a small key pool at a given age limit
   task automatic run_random_phase(int n_items, logic [AGE_W-1:0] limit, bit quiet);
      int r;
      cmd_type c;
      logic [KEY_W-1:0] k;
      wait_idle();
      csr_write_age_limit(limit);
      csr_check_age_limit();
      no_idle = quiet;
      for (int n = 0; n < n_items; n++) begin
         r = $urandom_range(0, 99);
         if (r < 35) c = CMD_ADD;
         else if (r < 50) c = CMD_REMOVE;
         else if (r < 75) c = CMD_LOOKUP;
         else c = CMD_TICK;
         if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
         else k = $urandom;
         send_item(c, k, $urandom);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_traffic();
      run_random_phase(18, 8'd1, 1'b0);
      run_random_phase(18, 8'd255, 1'b0);
      run_random_phase(18, AGE_W'($urandom_range(2, 6)), 1'b1);
      run_random_phase(18, 8'd3, 1'b0);
   endtask

   initial begin
      for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_basic_commands();
      test_full_table();
      test_zero_age();
      test_random_traffic();
      wait_idle();
      $display("summary: %0d commands, %0d results (%0d evictions) checked",
               commands_sent, results_checked, evictions_seen);
      $display("summary: %0d age limit writes, zero through 255, %0d mismatches",
               limit_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: keyed_table_with_age_eviction.f
+incdir+rtl
rtl/kta_pkg.sv
rtl/kta_cell.sv
rtl/keyed_table_with_age_eviction.sv
rtl/kta_checker.sv
test/keyed_table_with_age_eviction_tb.sv
